[sv/ljsr_pkg.sv]
// Shared types and constants for lossless JPEG sample reconstruction.
package ljsr_pkg;

  localparam int ROW_SAMPLES = 16384;
  localparam int ROW_AW = $clog2(ROW_SAMPLES);
  localparam int STORE_AW = ROW_AW + 1;
  localparam int STORE_DEPTH = 2 * ROW_SAMPLES;
  localparam int MAX_COMPONENTS = 6;
  localparam int COMP_W = 3;
  localparam int SAMPLE_W = 16;
  localparam int DIFF_W = 18;
  localparam int PRED_W = 34;
  localparam int POS_W = 19;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [2:0] REG_PRECISION = 3'd0;
  localparam logic [2:0] REG_PREDICTOR = 3'd1;
  localparam logic [2:0] REG_COMPONENTS = 3'd2;
  localparam logic [2:0] REG_COLUMNS = 3'd3;
  localparam logic [2:0] REG_SHARED = 3'd4;
  localparam logic [2:0] REG_RESTART = 3'd5;
  localparam logic [2:0] REG_LEN16 = 3'd6;

  localparam logic [2:0] PRED_LEFT = 3'd1;
  localparam logic [2:0] PRED_ABOVE = 3'd2;
  localparam logic [2:0] PRED_DIAG = 3'd3;
  localparam logic [2:0] PRED_PLANE = 3'd4;
  localparam logic [2:0] PRED_LEFT_HALF = 3'd5;
  localparam logic [2:0] PRED_ABOVE_HALF = 3'd6;
  localparam logic [2:0] PRED_AVG = 3'd7;

  typedef struct packed {
    logic        first_of_image;
    logic [4:0]  diff_length;
    logic [15:0] diff_bits;
  } diff_item_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        out_of_range;
    logic [2:0]  component_index;
    logic        last_of_row;
  } sample_item_t;

  typedef struct packed {
    logic [4:0]  precision;
    logic [2:0]  predictor_select;
    logic [2:0]  components;
    logic [15:0] columns;
    logic [1:0]  shared_chroma_count;
    logic [30:0] restart_interval;
    logic        length16_is_fixed;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic addr;
    logic rd1;
    logic rd2;
    logic pred;
    logic wb;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic row_end;
    logic mod_done;
  } status_t;

endpackage

[sv/lossless_jpeg_sample_reconstruct.sv]
// Top level: APB register file, controller and datapath.
//
//  channel    dir  handshake                  payload
//  diff       in   diff_valid / diff_stall     diff_data (diff_item_t)
//  sample     out  sample_valid / sample_stall sample_data (sample_item_t)
//  apb        in   psel / penable / pready     paddr, pwdata, prdata
//
//  After its transfer an item steps through address, two reads, predict and write-back, with
//  the input stalled meanwhile; the result sits in an output register. The next transfer is
//  taken the cycle after write-back, or after the bit-serial restart remainder at a row end.
//  Reset is synchronous; the row store is not cleared and holds garbage until written.
//  A stalled result holds write-back of the next item; the input stays stalled meanwhile.
module lossless_jpeg_sample_reconstruct import ljsr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                diff_valid,
  output logic                diff_stall,
  input  diff_item_t          diff_data,
  output logic                sample_valid,
  input  logic                sample_stall,
  output sample_item_t        sample_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic [2:0] reg_index;

  assign pready = 1'b1;
  assign reg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.precision <= 5'd16;
      cfg.predictor_select <= 3'd1;
      cfg.components <= 3'd1;
      cfg.columns <= 16'd1;
      cfg.shared_chroma_count <= 2'd0;
      cfg.restart_interval <= 31'h7FFF_FFFF;
      cfg.length16_is_fixed <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_index)
        REG_PRECISION:  cfg.precision <= pwdata[4:0];
        REG_PREDICTOR:  cfg.predictor_select <= pwdata[2:0];
        REG_COMPONENTS: cfg.components <= pwdata[2:0];
        REG_COLUMNS:    cfg.columns <= pwdata[15:0];
        REG_SHARED:     cfg.shared_chroma_count <= pwdata[1:0];
        REG_RESTART:    cfg.restart_interval <= pwdata[30:0];
        REG_LEN16:      cfg.length16_is_fixed <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_PRECISION:  prdata = {27'd0, cfg.precision};
      REG_PREDICTOR:  prdata = {29'd0, cfg.predictor_select};
      REG_COMPONENTS: prdata = {29'd0, cfg.components};
      REG_COLUMNS:    prdata = {16'd0, cfg.columns};
      REG_SHARED:     prdata = {30'd0, cfg.shared_chroma_count};
      REG_RESTART:    prdata = {1'b0, cfg.restart_interval};
      REG_LEN16:      prdata = {31'd0, cfg.length16_is_fixed};
      default:        prdata = '0;
    endcase
  end

  ljsr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .diff_valid (diff_valid),
    .diff_stall (diff_stall),
    .status     (status),
    .cmd        (cmd)
  );

  ljsr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .diff_data    (diff_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_data  (sample_data)
  );

endmodule

[sv/ljsr_mod.sv]
// Bit-serial remainder unit for the restart interval position.
module ljsr_mod import ljsr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [30:0] divisor,
  output logic        done,
  output logic [30:0] remainder
);

  logic        busy;
  logic [4:0]  count;
  logic [31:0] num;
  logic [30:0] den;
  logic [30:0] r;
  logic [31:0] trial;
  logic [31:0] r_next;

  always_comb begin
    trial = {r, num[31]};
    if (trial >= {1'b0, den}) begin
      r_next = trial - {1'b0, den};
    end else begin
      r_next = trial;
    end
  end

  assign done = busy && (&count);
  assign remainder = r_next[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 5'd1;
      if (&count) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      r <= '0;
    end else if (busy) begin
      num <= {num[30:0], 1'b0};
      r <= r_next[30:0];
    end
  end

endmodule

[sv/ljsr_dp.sv]
// Datapath: position counters, row store, predictors and result register.
module ljsr_dp import ljsr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  cmd_t         cmd,
  output status_t      status,
  input  diff_item_t   diff_data,
  output logic         sample_valid,
  input  logic         sample_stall,
  output sample_item_t sample_data
);

  logic [SAMPLE_W-1:0] row_mem [0:STORE_DEPTH-1];
  logic [31:0]         colpred [0:MAX_COMPONENTS-1];

  diff_item_t          in_q;
  logic [15:0]         col;
  logic [COMP_W-1:0]   comp;
  logic                parity;
  logic                past_first;
  logic [30:0]         remainder;
  logic [SAMPLE_W-1:0] shared;

  logic [15:0]         col_q;
  logic [COMP_W-1:0]   c_q;
  logic [POS_W-1:0]    pos_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic [SAMPLE_W-1:0] left_q;
  logic [SAMPLE_W-1:0] above_q;
  logic signed [PRED_W-1:0] pred_q;
  logic [SAMPLE_W-1:0] rd_a;
  logic [SAMPLE_W-1:0] rd_b;

  logic [4:0]          p_eff;
  logic [COMP_W-1:0]   nc_eff;
  logic [15:0]         ncols_eff;
  logic [30:0]         int_eff;

  logic [COMP_W-1:0]   c_cl;
  logic [POS_W-1:0]    pos_calc;
  logic [POS_W-1:0]    pos_m;
  logic [STORE_AW-1:0] addr_a;
  logic [STORE_AW-1:0] addr_b;

  logic [4:0]          len_eff;
  logic [4:0]          len_m1;
  logic [16:0]         full;
  logic [16:0]         masked;
  logic signed [DIFF_W-1:0] diff_calc;

  logic                col_nz;
  logic                use_shared;
  logic                use_colpred;
  logic signed [PRED_W-1:0] base;
  logic signed [PRED_W-1:0] above_s;
  logic signed [PRED_W-1:0] diag_s;
  logic signed [PRED_W-1:0] pred_calc;
  logic signed [PRED_W-1:0] value;
  logic                oor;
  logic                comp_last;
  logic                col_last;
  logic                mod_start;
  logic [31:0]         mod_dividend;
  logic                mod_done;
  logic [30:0]         mod_rem;

  always_comb begin
    p_eff = cfg.precision;
    if (cfg.precision == 5'd0) begin
      p_eff = 5'd1;
    end else if (cfg.precision > 5'd16) begin
      p_eff = 5'd16;
    end
    nc_eff = cfg.components;
    if (cfg.components == '0) begin
      nc_eff = COMP_W'(1);
    end else if (cfg.components > COMP_W'(MAX_COMPONENTS)) begin
      nc_eff = COMP_W'(MAX_COMPONENTS);
    end
    ncols_eff = (cfg.columns == '0) ? 16'd1 : cfg.columns;
    int_eff = (cfg.restart_interval == '0) ? 31'd1 : cfg.restart_interval;
  end

  // difference category decode
  always_comb begin
    len_eff = (in_q.diff_length > 5'd16) ? 5'd16 : in_q.diff_length;
    len_m1 = len_eff - 5'd1;
    full = (17'd1 << len_eff) - 17'd1;
    masked = {1'b0, in_q.diff_bits} & full;
    if (len_eff == 5'd0) begin
      diff_calc = '0;
    end else if (len_eff == 5'd16 && cfg.length16_is_fixed) begin
      diff_calc = -18'sd32768;
    end else if (!masked[len_m1]) begin
      diff_calc = $signed({1'b0, masked}) - $signed({1'b0, full});
    end else begin
      diff_calc = $signed({1'b0, masked});
    end
  end

  assign c_cl = (comp >= nc_eff) ? nc_eff - COMP_W'(1) : comp;
  assign pos_calc = POS_W'(col) * POS_W'(nc_eff) + POS_W'(c_cl);
  assign pos_m = pos_q - POS_W'(nc_eff);

  assign addr_a = cmd.rd1 ? {parity, pos_m[ROW_AW-1:0]} : {~parity, pos_m[ROW_AW-1:0]};
  assign addr_b = {~parity, pos_q[ROW_AW-1:0]};

  // predictor selection
  always_comb begin
    col_nz = (col_q != '0);
    use_shared = (cfg.shared_chroma_count != '0) && (c_q <= {1'b0, cfg.shared_chroma_count})
                 && (col_nz || (c_q != '0));
    use_colpred = !use_shared && !col_nz;
    above_s = $signed({{(PRED_W-SAMPLE_W){1'b0}}, above_q});
    diag_s = $signed({{(PRED_W-SAMPLE_W){1'b0}}, rd_a});
    if (use_shared) begin
      base = $signed({{(PRED_W-SAMPLE_W){1'b0}}, shared});
    end else if (col_nz) begin
      base = $signed({{(PRED_W-SAMPLE_W){1'b0}}, left_q});
    end else begin
      base = $signed({{(PRED_W-32){colpred[c_q][31]}}, colpred[c_q]});
    end
    pred_calc = base;
    if (past_first && col_nz) begin
      case (cfg.predictor_select)
        PRED_LEFT:       pred_calc = base;
        PRED_ABOVE:      pred_calc = above_s;
        PRED_DIAG:       pred_calc = diag_s;
        PRED_PLANE:      pred_calc = base + above_s - diag_s;
        PRED_LEFT_HALF:  pred_calc = base + ((above_s - diag_s) >>> 1);
        PRED_ABOVE_HALF: pred_calc = above_s + ((base - diag_s) >>> 1);
        PRED_AVG:        pred_calc = (base + above_s) >>> 1;
        default:         pred_calc = '0;
      endcase
    end
  end

  always_comb begin
    value = pred_q + $signed({{(PRED_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q});
    oor = ((value >>> p_eff) != '0);
    comp_last = (({1'b0, c_q} + 4'd1) >= {1'b0, nc_eff});
    col_last = (({1'b0, col_q} + 17'd1) >= {1'b0, ncols_eff});
  end

  assign mod_start = cmd.wb && comp_last && col_last;
  assign mod_dividend = {1'b0, remainder} + {16'd0, ncols_eff};

  assign status.out_free = !sample_valid || !sample_stall;
  assign status.row_end = comp_last && col_last;
  assign status.mod_done = mod_done;

  ljsr_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (int_eff),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      row_mem[{parity, pos_q[ROW_AW-1:0]}] <= value[SAMPLE_W-1:0];
    end
    if (cmd.rd1 || cmd.rd2) begin
      rd_a <= row_mem[addr_a];
    end
    if (cmd.rd1) begin
      rd_b <= row_mem[addr_b];
    end
  end

  // position and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      comp <= '0;
      parity <= 1'b0;
      past_first <= 1'b0;
      remainder <= '0;
      shared <= '0;
      for (int i = 0; i < MAX_COMPONENTS; i++) begin
        colpred[i] <= '0;
      end
    end else begin
      if (cmd.load && diff_data.first_of_image) begin
        col <= '0;
        comp <= '0;
        parity <= 1'b0;
        past_first <= 1'b0;
        remainder <= '0;
      end
      if (cmd.addr && col == '0 && c_cl == '0) begin
        shared <= '0;
        if (remainder == '0) begin
          for (int i = 0; i < MAX_COMPONENTS; i++) begin
            colpred[i] <= 32'd1 << (p_eff - 5'd1);
          end
        end
      end
      if (cmd.pred && use_colpred) begin
        colpred[c_q] <= colpred[c_q] + {{(32-DIFF_W){diff_q[DIFF_W-1]}}, diff_q};
      end
      if (cmd.wb) begin
        if (c_q <= {1'b0, cfg.shared_chroma_count}) begin
          shared <= value[SAMPLE_W-1:0];
        end
        if (comp_last) begin
          comp <= '0;
          if (col_last) begin
            col <= '0;
            parity <= ~parity;
            past_first <= 1'b1;
          end else begin
            col <= col_q + 16'd1;
          end
        end else begin
          comp <= c_q + COMP_W'(1);
        end
      end
      if (mod_done) begin
        remainder <= mod_rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_q <= diff_data;
    end
    if (cmd.addr) begin
      col_q <= col;
      c_q <= c_cl;
      pos_q <= pos_calc;
      diff_q <= diff_calc;
    end
    if (cmd.rd2) begin
      left_q <= rd_a;
      above_q <= rd_b;
    end
    if (cmd.pred) begin
      pred_q <= pred_calc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (cmd.wb) begin
      sample_valid <= 1'b1;
    end else if (!sample_stall) begin
      sample_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      sample_data.sample <= value[SAMPLE_W-1:0];
      sample_data.out_of_range <= oor;
      sample_data.component_index <= c_q;
      sample_data.last_of_row <= comp_last && col_last;
    end
  end

`ifndef SYNTHESIS
  a_result_from_wb: assert property (@(posedge clk) disable iff (rst)
    $rose(sample_valid) |-> $past(cmd.wb))
    else $error("result appeared without a write-back");

  a_comp_clamped: assert property (@(posedge clk) disable iff (rst)
    cmd.pred |-> c_q < COMP_W'(MAX_COMPONENTS))
    else $error("component index beyond the predictor bank");

  a_row_flip: assert property (@(posedge clk) disable iff (rst)
    mod_start |=> parity != $past(parity))
    else $error("row end without a parity flip");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    mod_done |=> remainder < $past(int_eff))
    else $error("restart remainder not below the interval");
`endif

endmodule

[sv/ljsr_ctrl.sv]
// Controller: sequences a transfer: address, reads, predict, write-back, remainder.
module ljsr_ctrl import ljsr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    diff_valid,
  output logic    diff_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ADDR = 7'b0000010,
    S_RD1  = 7'b0000100,
    S_RD2  = 7'b0001000,
    S_PRED = 7'b0010000,
    S_WB   = 7'b0100000,
    S_MOD  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (diff_valid) begin
          cmd.load = 1'b1;
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.addr = 1'b1;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.rd1 = 1'b1;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.rd2 = 1'b1;
        state_next = S_PRED;
      end
      S_PRED: begin
        cmd.pred = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        if (status.out_free) begin
          cmd.wb = 1'b1;
          state_next = status.row_end ? S_MOD : S_IDLE;
        end
      end
      S_MOD: begin
        if (status.mod_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign diff_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_wb_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.wb |-> status.out_free)
    else $error("write-back while the result register is held");

  a_load_to_addr: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_ADDR)
    else $error("transfer not followed by address step");

  a_mod_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD) && status.mod_done |=> !diff_stall)
    else $error("remainder done but input still stalled");
`endif

endmodule

[bench/lossless_jpeg_sample_reconstruct_tb.sv]
// Self-checking testbench for lossless JPEG sample reconstruction.
`timescale 1ns / 100ps

module lossless_jpeg_sample_reconstruct_tb;
  import ljsr_pkg::*;

  localparam logic [2:0] PRED_NONE = 3'd0;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned PHASES = 20;
  localparam int unsigned WIDE_COLS = 2731;
  localparam int unsigned WIDE_ITEMS = 48;
  localparam int unsigned TYPED_ROWS = 11;
  localparam int unsigned DIRECTED_ROWS = 18;

  typedef enum logic [1:0] {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_mode_t;

  typedef struct packed {
    logic         typed;
    diff_item_t   item;
    sample_item_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic diff_valid = 1'b0;
  logic diff_stall;
  diff_item_t diff_data = '0;
  logic sample_valid;
  logic sample_stall = 1'b0;
  sample_item_t sample_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  lossless_jpeg_sample_reconstruct i_dut (
    .clk          (clk),
    .rst          (rst),
    .diff_valid   (diff_valid),
    .diff_stall   (diff_stall),
    .diff_data    (diff_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_data  (sample_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  cfg_t cfg = '{precision: 5'd16, predictor_select: PRED_LEFT, components: 3'd1,
                columns: 16'd1, shared_chroma_count: 2'd0,
                restart_interval: 31'h7FFF_FFFF, length16_is_fixed: 1'b1};
  logic [15:0] row_mem [0:STORE_DEPTH-1];
  logic [31:0] col_pred [0:MAX_COMPONENTS-1] = '{default: '0};
  logic [15:0] shared_val = '0;
  int unsigned col_cnt = 0;
  int unsigned comp_cnt = 0;
  logic parity = 1'b0;
  logic past_first = 1'b0;
  longint unsigned remainder = 0;

  sample_item_t pending_samples [$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned samples_checked = 0;
  int unsigned flagged_samples = 0;
  int unsigned settings_applied = 0;
  int unsigned burst_left = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{1'b1, '{1'b1, 5'd0,  16'h0000}, '{16'h8000, 1'b0, 3'd0, 1'b1}},
    '{1'b1, '{1'b0, 5'd16, 16'h1234}, '{16'h0000, 1'b0, 3'd0, 1'b1}},
    '{1'b1, '{1'b0, 5'd1,  16'h0000}, '{16'hFFFF, 1'b1, 3'd0, 1'b1}},
    '{1'b1, '{1'b0, 5'd1,  16'h0001}, '{16'h0000, 1'b0, 3'd0, 1'b1}},
    '{1'b1, '{1'b0, 5'd16, 16'hFFFF}, '{16'h8000, 1'b1, 3'd0, 1'b1}},
    '{1'b1, '{1'b0, 5'd31, 16'h0000}, '{16'h0000, 1'b1, 3'd0, 1'b1}},
    '{1'b1, '{1'b1, 5'd15, 16'h7FFF}, '{16'hFFFF, 1'b0, 3'd0, 1'b1}},
    '{1'b1, '{1'b0, 5'd2,  16'h0002}, '{16'h0001, 1'b1, 3'd0, 1'b1}},
    '{1'b1, '{1'b0, 5'd2,  16'h0001}, '{16'hFFFF, 1'b0, 3'd0, 1'b1}},
    '{1'b1, '{1'b0, 5'd15, 16'h0000}, '{16'h8000, 1'b0, 3'd0, 1'b1}},
    '{1'b1, '{1'b0, 5'd4,  16'hFFF5}, '{16'h7FF6, 1'b0, 3'd0, 1'b1}},
    '{1'b0, '{1'b1, 5'd16, 16'h8000}, '0},
    '{1'b0, '{1'b0, 5'd16, 16'h0000}, '0},
    '{1'b0, '{1'b0, 5'd16, 16'hFFFF}, '0},
    '{1'b0, '{1'b0, 5'd3,  16'hFFF8}, '0},
    '{1'b0, '{1'b0, 5'd20, 16'h7FFF}, '0},
    '{1'b0, '{1'b0, 5'd1,  16'h0001}, '0},
    '{1'b0, '{1'b0, 5'd0,  16'hFFFF}, '0}
  };

  function automatic int unsigned store_index(logic par, int unsigned pos);
    return (par ? ROW_SAMPLES : 0) + pos % ROW_SAMPLES;
  endfunction

  function automatic sample_item_t reconstruct(diff_item_t it);
    int unsigned prec, ncomp, ncols, interval, col, comp, pos, sraw, len;
    longint full, bits, diff, pred, above, above_left, value;
    sample_item_t r;
    prec = cfg.precision;
    if (prec < 1) prec = 1;
    if (prec > 16) prec = 16;
    ncomp = cfg.components;
    if (ncomp < 1) ncomp = 1;
    if (ncomp > MAX_COMPONENTS) ncomp = MAX_COMPONENTS;
    ncols = cfg.columns;
    if (ncols < 1) ncols = 1;
    interval = (cfg.restart_interval == 0) ? 1 : cfg.restart_interval;
    sraw = cfg.shared_chroma_count;

    if (it.first_of_image) begin
      col_cnt = 0;
      comp_cnt = 0;
      parity = 1'b0;
      past_first = 1'b0;
      remainder = 0;
    end
    col = col_cnt;
    comp = comp_cnt;
    if (comp >= ncomp) comp = ncomp - 1;

    if (col == 0 && comp == 0) begin
      shared_val = '0;
      if (remainder == 0) begin
        foreach (col_pred[i]) col_pred[i] = 32'd1 << (prec - 1);
      end
    end

    len = it.diff_length;
    if (len > 16) len = 16;
    if (len == 0) begin
      diff = 0;
    end else if (len == 16 && cfg.length16_is_fixed) begin
      diff = -32768;
    end else begin
      full = (longint'(1) << len) - 1;
      bits = longint'(it.diff_bits) & full;
      diff = ((bits >> (len - 1)) & 1) ? bits : bits - full;
    end

    pos = col * ncomp + comp;
    if (sraw != 0 && comp <= sraw && (col != 0 || comp != 0)) begin
      pred = longint'(shared_val);
    end else if (col != 0) begin
      pred = longint'(row_mem[store_index(parity, pos - ncomp)]);
    end else begin
      pred = longint'(signed'(col_pred[comp]));
      col_pred[comp] = col_pred[comp] + diff[31:0];
    end

    if (past_first && col != 0) begin
      above = longint'(row_mem[store_index(!parity, pos)]);
      above_left = longint'(row_mem[store_index(!parity, pos - ncomp)]);
      case (cfg.predictor_select)
        PRED_LEFT: ;
        PRED_ABOVE: pred = above;
        PRED_DIAG: pred = above_left;
        PRED_PLANE: pred = pred + above - above_left;
        PRED_LEFT_HALF: pred = pred + ((above - above_left) >>> 1);
        PRED_ABOVE_HALF: pred = above + ((pred - above_left) >>> 1);
        PRED_AVG: pred = (pred + above) >>> 1;
        default: pred = 0;
      endcase
    end

    value = pred + diff;
    row_mem[store_index(parity, pos)] = value[15:0];
    if (comp <= sraw) shared_val = value[15:0];

    r.sample = value[15:0];
    r.out_of_range = (value < 0) || ((value >>> prec) != 0);
    r.component_index = comp[2:0];
    r.last_of_row = (comp + 1 >= ncomp) && (col + 1 >= ncols);

    comp++;
    if (comp >= ncomp) begin
      comp = 0;
      col++;
      if (col >= ncols) begin
        col = 0;
        parity = !parity;
        past_first = 1'b1;
        remainder = (remainder + ncols) % interval;
      end
    end
    col_cnt = col & 16'hFFFF;
    comp_cnt = comp;
    return r;
  endfunction

  function automatic logic [31:0] reg_value(cfg_t s, logic [2:0] idx);
    case (idx)
      REG_PRECISION: return 32'(s.precision);
      REG_PREDICTOR: return 32'(s.predictor_select);
      REG_COMPONENTS: return 32'(s.components);
      REG_COLUMNS: return 32'(s.columns);
      REG_SHARED: return 32'(s.shared_chroma_count);
      REG_RESTART: return 32'(s.restart_interval);
      REG_LEN16: return 32'(s.length16_is_fixed);
      default: return '0;
    endcase
  endfunction

  function automatic diff_item_t random_item(logic first);
    diff_item_t it;
    int unsigned roll;
    roll = $urandom_range(0, 19);
    it.first_of_image = first;
    if (roll == 0) it.diff_length = 5'd0;
    else if (roll <= 2) it.diff_length = 5'd16;
    else if (roll == 3) it.diff_length = 5'($urandom_range(17, 31));
    else it.diff_length = 5'($urandom_range(1, 15));
    it.diff_bits = 16'($urandom);
    return it;
  endfunction

  task automatic read_reg(logic [2:0] idx, output logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    logic [31:0] rd;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_PRECISION: cfg.precision = val[4:0];
      REG_PREDICTOR: cfg.predictor_select = val[2:0];
      REG_COMPONENTS: cfg.components = val[2:0];
      REG_COLUMNS: cfg.columns = val[15:0];
      REG_SHARED: cfg.shared_chroma_count = val[1:0];
      REG_RESTART: cfg.restart_interval = val[30:0];
      REG_LEN16: cfg.length16_is_fixed = val[0];
      default: ;
    endcase
    read_reg(idx, rd);
    if (rd !== reg_value(cfg, idx)) begin
      $error("register %0d readback: expected %h, got %h", idx, reg_value(cfg, idx), rd);
      errors++;
    end
  endtask

  task automatic apply_setting(cfg_t s);
    write_reg(REG_PRECISION, reg_value(s, REG_PRECISION));
    write_reg(REG_PREDICTOR, reg_value(s, REG_PREDICTOR));
    write_reg(REG_COMPONENTS, reg_value(s, REG_COMPONENTS));
    write_reg(REG_COLUMNS, reg_value(s, REG_COLUMNS));
    write_reg(REG_SHARED, reg_value(s, REG_SHARED));
    write_reg(REG_RESTART, reg_value(s, REG_RESTART));
    write_reg(REG_LEN16, reg_value(s, REG_LEN16));
    settings_applied++;
  endtask

  task automatic send_item(diff_item_t it, logic typed, sample_item_t want);
    int unsigned gap;
    sample_item_t predicted;
    if (burst_left == 0) begin
      gap = quiet ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        diff_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    diff_valid <= 1'b1;
    diff_data <= it;
    @(posedge clk);
    while (diff_stall) @(posedge clk);
    predicted = reconstruct(it);
    pending_samples.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // Input idle until every expected sample is back, plus row-end settle time.
  task automatic drain();
    diff_valid <= 1'b0;
    burst_left = 0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sample sink: checks each transfer and drives its own stall pattern.
  initial begin : sample_sink
    int unsigned span;
    int unsigned hold_left;
    flow_mode_t mode;
    logic stall_next;
    sample_item_t want;
    span = 0;
    hold_left = 0;
    mode = FLOW_FREE;
    forever begin
      @(posedge clk);
      if (!rst && sample_valid && !sample_stall) begin
        if (pending_samples.size() == 0) begin
          $error("unexpected sample transfer: %h", sample_data);
          errors++;
        end else begin
          want = pending_samples.pop_front();
          samples_checked++;
          if (sample_data.out_of_range === 1'b1) flagged_samples++;
          if (sample_data.sample !== want.sample) begin
            $error("sample: expected %h, got %h", want.sample, sample_data.sample);
            errors++;
          end
          if (sample_data.out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %b, got %b", want.out_of_range,
                   sample_data.out_of_range);
            errors++;
          end
          if (sample_data.component_index !== want.component_index) begin
            $error("component_index: expected %0d, got %0d", want.component_index,
                   sample_data.component_index);
            errors++;
          end
          if (sample_data.last_of_row !== want.last_of_row) begin
            $error("last_of_row: expected %b, got %b", want.last_of_row,
                   sample_data.last_of_row);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (span == 0) begin
        mode = flow_mode_t'($urandom_range(0, 3));
        span = $urandom_range(20, 120);
      end
      span--;
      if (hold_left != 0) begin
        stall_next = 1'b1;
        hold_left--;
      end else if (quiet) begin
        stall_next = 1'b0;
      end else begin
        case (mode)
          FLOW_FREE: stall_next = 1'b0;
          FLOW_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
          FLOW_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
          default: stall_next = (span % 3 == 0);
        endcase
      end
      sample_stall <= stall_next;
    end
  end

  initial begin : stimulus
    logic [31:0] rd;
    logic [2:0] reg_list [0:6];
    cfg_t s;
    int unsigned n;
    reg_list = '{REG_PRECISION, REG_PREDICTOR, REG_COMPONENTS, REG_COLUMNS,
                 REG_SHARED, REG_RESTART, REG_LEN16};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    foreach (reg_list[i]) begin
      read_reg(reg_list[i], rd);
      if (rd !== reg_value(cfg, reg_list[i])) begin
        $error("register %0d after reset: expected %h, got %h", reg_list[i],
               reg_value(cfg, reg_list[i]), rd);
        errors++;
      end
    end

    // Directed: difference decoding extremes, then the non-fixed category 16
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (i == TYPED_ROWS) begin
        drain();
        write_reg(REG_LEN16, 32'd0);
        write_reg(REG_PRECISION, 32'd0);
      end
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end
    drain();

    // Counters left past the new bounds after a geometry change mid-row
    s = '{precision: 5'd12, predictor_select: PRED_PLANE, components: 3'd2, columns: 16'd8,
          shared_chroma_count: 2'd0, restart_interval: 31'd3, length16_is_fixed: 1'b1};
    apply_setting(s);
    for (int k = 0; k < 26; k++) send_item(random_item(k == 0), 1'b0, '0);
    drain();
    write_reg(REG_COLUMNS, 32'd3);
    for (int k = 0; k < 5; k++) send_item(random_item(1'b0), 1'b0, '0);
    drain();
    write_reg(REG_COMPONENTS, 32'd1);
    for (int k = 0; k < 6; k++) send_item(random_item(1'b0), 1'b0, '0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: s = '{precision: 5'd1, predictor_select: PRED_AVG, components: 3'd6,
                 columns: 16'd1, shared_chroma_count: 2'd3, restart_interval: 31'd1,
                 length16_is_fixed: 1'b0};
        1: s = '{precision: 5'd16, predictor_select: PRED_LEFT, components: 3'd1,
                 columns: 16'hFFFF, shared_chroma_count: 2'd0,
                 restart_interval: 31'h7FFF_FFFF, length16_is_fixed: 1'b1};
        2: s = '{precision: 5'd31, predictor_select: PRED_NONE, components: 3'd7,
                 columns: 16'd0, shared_chroma_count: 2'd2, restart_interval: 31'd0,
                 length16_is_fixed: 1'b1};
        3: s = '{precision: 5'd0, predictor_select: PRED_PLANE, components: 3'd0,
                 columns: 16'd9, shared_chroma_count: 2'd1, restart_interval: 31'd2,
                 length16_is_fixed: 1'b0};
        default: begin
          s.precision = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                    : 5'($urandom_range(1, 16));
          s.predictor_select = 3'(ph % 8);
          s.components = 3'($urandom_range(1, 6));
          s.columns = 16'($urandom_range(1, 10));
          s.shared_chroma_count = 2'($urandom_range(0, 3));
          s.restart_interval = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                           : 31'($urandom_range(1, 30));
          s.length16_is_fixed = 1'($urandom_range(0, 1));
        end
      endcase
      apply_setting(s);
      if (ph == 3) hold_req = 1'b1;
      n = $urandom_range(20, 32);
      for (int k = 0; k < n; k++) begin
        send_item(random_item((k == 0) || ($urandom_range(0, 79) == 0)), 1'b0, '0);
        if ($urandom_range(0, 99) == 0) drain();
      end
      drain();
    end

    // Start of one very wide row with every component, sent back to back
    quiet = 1'b1;
    s = '{precision: 5'd16, predictor_select: PRED_LEFT_HALF, components: 3'd6,
          columns: 16'(WIDE_COLS), shared_chroma_count: 2'd0,
          restart_interval: 31'($urandom_range(1, 5000)), length16_is_fixed: 1'b1};
    apply_setting(s);
    for (int k = 0; k < WIDE_ITEMS; k++) send_item(random_item(k == 0), 1'b0, '0);
    drain();
    quiet = 1'b0;

    $display("covered %0d difference transfers over %0d register settings,", items_sent,
             settings_applied);
    $display("%0d samples checked, %0d of them flagged out of range", samples_checked,
             flagged_samples);
    if (errors == 0) begin
      $display("lossless_jpeg_sample_reconstruct regression: pass");
    end else begin
      $display("lossless_jpeg_sample_reconstruct regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("lossless_jpeg_sample_reconstruct regression: fail");
    $finish;
  end

endmodule
